// File: hw/rtl/bsmv_pkg.sv
`timescale 1ns / 1ps

package bsmv_pkg;

    // Sizes fixed by the beat layout
    localparam int MAX_FEATURES_DEF = 4096;
    localparam int LANES            = 8;
    localparam int LANE_SEL_W       = $clog2(LANES);
    localparam int PAIRS            = LANES / 2;
    localparam int X_W              = 16;
    localparam int SCALE_W          = 16;
    localparam int SIGN_W           = LANES;
    localparam int ELEM_W           = 32;
    localparam int PAIR_W           = ELEM_W + 1;
    localparam int SUM_W            = ELEM_W + LANE_SEL_W;
    localparam int CFG_W            = 13;
    localparam int OUT_W            = 32;
    localparam int OUT_SHIFT        = 28;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;

    localparam logic [CFG_W-1:0] LEN_RESET = 13'd4096;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHUNK = 1'b1;

    // Register index (word address)
    localparam logic [0:0] REG_VECTOR_LENGTH = 1'b0;

    typedef struct packed {
        logic                      op;
        logic signed [X_W-1:0]     x_value;
        logic signed [SCALE_W-1:0] column_scale;
        logic [SIGN_W-1:0]         sign_bits;
        logic signed [SCALE_W-1:0] row_scale;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] row_value;
        logic                    saturated;
    } out_beat_t;

    // Per-lane strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic s2_load;
    } lane_ctrl_t;

    // Stage load strobes for the merge and scale stages
    typedef struct packed {
        logic s3_load;
        logic s4_load;
        logic acc_upd;
        logic s5_load;
        logic s6_load;
        logic out_load;
    } pipe_en_t;

endpackage

// File: hw/rtl/binary_sign_matrix_vector.sv
`timescale 1ns / 1ps

// Binary sign matrix-vector unit.
// Input channel (in_valid / in_stall / in_data): a load beat (op load) stores
// x_value * column_scale at the next vector position; once vector_length
// elements are stored the vector is ready. A chunk beat (op chunk) brings eight
// row signs, first element in the MSB; chunks before the vector is ready are
// dropped. The chunk that covers the last element gives one result beat on
// out_valid / out_stall / out_data: (row_scale * row sum) >> 28, clipped.
// Both kinds of beat are taken one per cycle while in_stall is low: eight lanes,
// each with its own bank of the vector store, read the eight elements of a chunk
// in one cycle. A row result goes through s1 to s6 and the output register.
// A stalled result holds in the output register while the lanes, the adder
// tree and the scaling stages keep filling; in_stall rises only when all of
// them are full behind it.
// Writing vector_length over the APB port (offset 0) restarts loading.
// Reset sets vector_length to 4096 and empties the vector and the pipeline;
// there is no clearing pass and the block takes beats right away.

module binary_sign_matrix_vector #(
    parameter int MAX_FEATURES = bsmv_pkg::MAX_FEATURES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsmv_pkg::ADDR_W-1:0]   paddr,
    input  logic [bsmv_pkg::DATA_W-1:0]   pwdata,
    output logic [bsmv_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bsmv_pkg::in_beat_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bsmv_pkg::out_beat_t           out_data
);

    localparam int LANES      = bsmv_pkg::LANES;
    localparam int SEL_W      = bsmv_pkg::LANE_SEL_W;
    localparam int BANK_DEPTH = (MAX_FEATURES + LANES - 1) / LANES;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int LEN_W      = $clog2(MAX_FEATURES + 1);
    localparam int POS_W      = (LEN_W > BANK_AW + SEL_W) ? LEN_W : BANK_AW + SEL_W;
    localparam int ACC_W      = bsmv_pkg::ELEM_W + $clog2(MAX_FEATURES);

    typedef struct packed {
        logic                                first;
        logic                                last;
        logic signed [bsmv_pkg::SCALE_W-1:0] row_scale;
    } meta_t;

    logic [bsmv_pkg::CFG_W-1:0]  vector_length_reg;
    logic                        cfg_write;
    logic                        reg_hit;
    logic [POS_W-1:0]            len;

    logic [POS_W-1:0]            load_pos_reg;
    logic                        vector_ready_reg;
    logic [BANK_AW-1:0]          chunk_pos_reg;

    logic                        in_accept;
    logic                        load_acc;
    logic                        chunk_acc;
    logic [POS_W-1:0]            pos_eff;
    logic [POS_W:0]              pos_inc;
    logic                        load_done;
    logic signed [bsmv_pkg::ELEM_W-1:0] elem_value;
    logic [SEL_W-1:0]            wr_bank;
    logic [BANK_AW-1:0]          wr_addr;
    logic [POS_W:0]              chunk_base;
    logic [LANES-1:0]            lane_use;
    logic                        chunk_last;
    logic                        chunk_first;

    logic                        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                        s5_valid_reg, s6_valid_reg, out_valid_reg;
    meta_t                       s1_meta_reg, s2_meta_reg, s3_meta_reg, s4_meta_reg;
    logic signed [bsmv_pkg::SCALE_W-1:0] s5_scale_reg;
    logic                        out_free;
    logic                        s1_move, s2_move, s3_move, s4_move, s5_move, s6_move;
    logic                        s1_free, s2_free, s3_free, s4_free, s5_free, s6_free;

    bsmv_pkg::lane_ctrl_t        lane_ctrl [LANES];
    logic [LANES-1:0][bsmv_pkg::ELEM_W-1:0] lane_contrib;
    bsmv_pkg::pipe_en_t          pipe_en;
    logic signed [ACC_W-1:0]     row_sum;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_hit   = (paddr[bsmv_pkg::ADDR_W-1:2] == bsmv_pkg::REG_VECTOR_LENGTH);
    assign prdata    = reg_hit ? bsmv_pkg::DATA_W'(vector_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= bsmv_pkg::LEN_RESET;
        end
        else if (cfg_write && reg_hit)
        begin
            vector_length_reg <= pwdata[bsmv_pkg::CFG_W-1:0];
        end
    end

    // Clamp the length into one to the store depth
    always_comb
    begin
        if (vector_length_reg == '0)
        begin
            len = POS_W'(1);
        end
        else if (32'(vector_length_reg) > 32'(MAX_FEATURES))
        begin
            len = POS_W'(MAX_FEATURES);
        end
        else
        begin
            len = POS_W'(vector_length_reg);
        end
    end

    // Beat decode
    assign in_accept = in_valid & ~in_stall;
    assign load_acc  = in_accept & (in_data.op == bsmv_pkg::OP_LOAD);
    assign chunk_acc = in_accept & (in_data.op == bsmv_pkg::OP_CHUNK) & vector_ready_reg;

    // Load path: product goes straight into its bank
    assign pos_eff    = (load_pos_reg >= len) ? '0 : load_pos_reg;
    assign pos_inc    = {1'b0, pos_eff} + (POS_W+1)'(1);
    assign load_done  = pos_inc >= {1'b0, len};
    assign elem_value = bsmv_pkg::ELEM_W'(in_data.x_value)
                      * bsmv_pkg::ELEM_W'(in_data.column_scale);
    assign wr_bank    = pos_eff[SEL_W-1:0];
    assign wr_addr    = pos_eff[BANK_AW+SEL_W-1:SEL_W];

    // Chunk path: which lanes fall inside the vector
    assign chunk_base  = (POS_W+1)'({chunk_pos_reg, {SEL_W{1'b0}}});
    assign chunk_last  = (chunk_base + (POS_W+1)'(LANES)) >= {1'b0, len};
    assign chunk_first = (chunk_pos_reg == '0);

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lane_use[k] = (chunk_base + (POS_W+1)'(k)) < {1'b0, len};
        end
    end

    // Load and row position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg     <= '0;
            vector_ready_reg <= 1'b0;
            chunk_pos_reg    <= '0;
        end
        else
        begin
            priority if (cfg_write && reg_hit)
            begin
                load_pos_reg     <= '0;
                vector_ready_reg <= 1'b0;
                chunk_pos_reg    <= '0;
            end
            else if (load_acc)
            begin
                vector_ready_reg <= load_done;
                load_pos_reg     <= load_done ? '0 : pos_inc[POS_W-1:0];
                chunk_pos_reg    <= '0;
            end
            else if (chunk_acc)
            begin
                chunk_pos_reg <= chunk_last ? '0 : chunk_pos_reg + BANK_AW'(1);
            end
            else
            begin
                chunk_pos_reg <= chunk_pos_reg;
            end
        end
    end

    // Stage advance, from the output back to the input
    assign out_free = ~out_valid_reg | ~out_stall;
    assign s6_move  = s6_valid_reg & out_free;
    assign s6_free  = ~s6_valid_reg | s6_move;
    assign s5_move  = s5_valid_reg & s6_free;
    assign s5_free  = ~s5_valid_reg | s5_move;
    assign s4_move  = s4_valid_reg & (~s4_meta_reg.last | s5_free);
    assign s4_free  = ~s4_valid_reg | s4_move;
    assign s3_move  = s3_valid_reg & s4_free;
    assign s3_free  = ~s3_valid_reg | s3_move;
    assign s2_move  = s2_valid_reg & s3_free;
    assign s2_free  = ~s2_valid_reg | s2_move;
    assign s1_move  = s1_valid_reg & s2_free;
    assign s1_free  = ~s1_valid_reg | s1_move;
    assign in_stall = ~s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= chunk_acc | (s1_valid_reg & ~s1_move);
            s2_valid_reg  <= s1_move | (s2_valid_reg & ~s2_move);
            s3_valid_reg  <= s2_move | (s3_valid_reg & ~s3_move);
            s4_valid_reg  <= s3_move | (s4_valid_reg & ~s4_move);
            s5_valid_reg  <= (s4_move & s4_meta_reg.last) | (s5_valid_reg & ~s5_move);
            s6_valid_reg  <= s5_move | (s6_valid_reg & ~s6_move);
            out_valid_reg <= s6_move | (out_valid_reg & ~out_free);
        end
    end

    // Row markers travel with each chunk
    always_ff @(posedge clk)
    begin
        if (chunk_acc)
        begin
            s1_meta_reg.first     <= chunk_first;
            s1_meta_reg.last      <= chunk_last;
            s1_meta_reg.row_scale <= in_data.row_scale;
        end
        if (s1_move)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
        if (s2_move)
        begin
            s3_meta_reg <= s2_meta_reg;
        end
        if (s3_move)
        begin
            s4_meta_reg <= s3_meta_reg;
        end
        if (pipe_en.s5_load)
        begin
            s5_scale_reg <= s4_meta_reg.row_scale;
        end
    end

    assign pipe_en.s3_load  = s2_move;
    assign pipe_en.s4_load  = s3_move;
    assign pipe_en.acc_upd  = s4_move & ~s4_meta_reg.last;
    assign pipe_en.s5_load  = s4_move & s4_meta_reg.last;
    assign pipe_en.s6_load  = s5_move;
    assign pipe_en.out_load = s6_move;

    // Lanes, one bank each
    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            assign lane_ctrl[g].wr_en   = load_acc & (wr_bank == SEL_W'(g));
            assign lane_ctrl[g].rd_en   = chunk_acc;
            assign lane_ctrl[g].s2_load = s1_move;

            bsmv_lane #(
                .BANK_DEPTH (BANK_DEPTH),
                .BANK_AW    (BANK_AW)
            ) u_lane (
                .clk       (clk),
                .ctrl      (lane_ctrl[g]),
                .wr_addr   (wr_addr),
                .wr_data   (elem_value),
                .rd_addr   (chunk_pos_reg),
                .sign_flag (in_data.sign_bits[LANES-1-g]),
                .use_bit   (lane_use[g]),
                .contrib   (lane_contrib[g])
            );
        end
    endgenerate

    bsmv_merge #(
        .ACC_W (ACC_W)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .first   (s4_meta_reg.first),
        .contrib (lane_contrib),
        .row_sum (row_sum)
    );

    bsmv_scale #(
        .ACC_W (ACC_W)
    ) u_scale (
        .clk       (clk),
        .en        (pipe_en),
        .row_sum   (row_sum),
        .row_scale (s5_scale_reg),
        .row_value (out_data.row_value),
        .saturated (out_data.saturated)
    );

    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/bsmv_lane.sv
`timescale 1ns / 1ps

module bsmv_lane #(
    parameter int BANK_DEPTH = bsmv_pkg::MAX_FEATURES_DEF / bsmv_pkg::LANES,
    parameter int BANK_AW    = $clog2(bsmv_pkg::MAX_FEATURES_DEF / bsmv_pkg::LANES)
) (
    input  logic                                clk,
    input  bsmv_pkg::lane_ctrl_t                ctrl,
    input  logic [BANK_AW-1:0]                  wr_addr,
    input  logic signed [bsmv_pkg::ELEM_W-1:0]  wr_data,
    input  logic [BANK_AW-1:0]                  rd_addr,
    input  logic                                sign_flag,
    input  logic                                use_bit,
    output logic signed [bsmv_pkg::ELEM_W-1:0]  contrib
);

    logic signed [bsmv_pkg::ELEM_W-1:0] bank [BANK_DEPTH];
    logic signed [bsmv_pkg::ELEM_W-1:0] rd_data_reg;
    logic                               sign_reg;
    logic                               use_reg;
    logic signed [bsmv_pkg::ELEM_W-1:0] contrib_next;
    logic signed [bsmv_pkg::ELEM_W-1:0] contrib_reg;

    // Bank write and registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            bank[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= bank[rd_addr];
            sign_reg    <= sign_flag;
            use_reg     <= use_bit;
        end
    end

    // Add, subtract or drop the element
    always_comb
    begin
        if (!use_reg)
        begin
            contrib_next = '0;
        end
        else if (sign_reg)
        begin
            contrib_next = rd_data_reg;
        end
        else
        begin
            contrib_next = -rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_load)
        begin
            contrib_reg <= contrib_next;
        end
    end

    assign contrib = contrib_reg;

endmodule

// File: hw/rtl/bsmv_merge.sv
`timescale 1ns / 1ps

module bsmv_merge #(
    parameter int ACC_W = bsmv_pkg::ELEM_W + $clog2(bsmv_pkg::MAX_FEATURES_DEF)
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  bsmv_pkg::pipe_en_t                                  en,
    input  logic                                                first,
    input  logic [bsmv_pkg::LANES-1:0][bsmv_pkg::ELEM_W-1:0]    contrib,
    output logic signed [ACC_W-1:0]                             row_sum
);

    logic signed [bsmv_pkg::PAIR_W-1:0] pair_next [bsmv_pkg::PAIRS];
    logic signed [bsmv_pkg::PAIR_W-1:0] pair_reg  [bsmv_pkg::PAIRS];
    logic signed [bsmv_pkg::SUM_W-1:0]  sum_next;
    logic signed [bsmv_pkg::SUM_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]            acc_base;
    logic signed [ACC_W-1:0]            acc_next;
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [ACC_W-1:0]            row_sum_reg;

    // First tree level: neighboring lanes
    always_comb
    begin
        for (int i = 0; i < bsmv_pkg::PAIRS; i++)
        begin
            pair_next[i] = bsmv_pkg::PAIR_W'($signed(contrib[2*i]))
                         + bsmv_pkg::PAIR_W'($signed(contrib[2*i+1]));
        end
    end

    // Second tree level: all pairs
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < bsmv_pkg::PAIRS; i++)
        begin
            sum_next = sum_next + bsmv_pkg::SUM_W'(pair_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3_load)
        begin
            for (int i = 0; i < bsmv_pkg::PAIRS; i++)
            begin
                pair_reg[i] <= pair_next[i];
            end
        end
        if (en.s4_load)
        begin
            sum_reg <= sum_next;
        end
    end

    // Start a row fresh on its first chunk
    assign acc_base = first ? '0 : acc_reg;
    assign acc_next = acc_base + ACC_W'(sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (en.acc_upd)
        begin
            acc_reg <= acc_next;
        end
    end

    // Hold the finished row sum for scaling
    always_ff @(posedge clk)
    begin
        if (en.s5_load)
        begin
            row_sum_reg <= acc_next;
        end
    end

    assign row_sum = row_sum_reg;

endmodule

// File: hw/rtl/bsmv_scale.sv
`timescale 1ns / 1ps

module bsmv_scale #(
    parameter int ACC_W = bsmv_pkg::ELEM_W + $clog2(bsmv_pkg::MAX_FEATURES_DEF)
) (
    input  logic                                 clk,
    input  bsmv_pkg::pipe_en_t                   en,
    input  logic signed [ACC_W-1:0]              row_sum,
    input  logic signed [bsmv_pkg::SCALE_W-1:0]  row_scale,
    output logic signed [bsmv_pkg::OUT_W-1:0]    row_value,
    output logic                                 saturated
);

    localparam int PROD_W  = bsmv_pkg::SCALE_W + ACC_W;
    localparam int SHIFT_W = PROD_W - bsmv_pkg::OUT_SHIFT;

    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [SHIFT_W-1:0]         shifted;
    logic signed [bsmv_pkg::OUT_W-1:0] value_next;
    logic                              sat_next;
    logic signed [bsmv_pkg::OUT_W-1:0] value_reg;
    logic                              sat_reg;

    // Apply the row scale
    always_ff @(posedge clk)
    begin
        if (en.s6_load)
        begin
            prod_reg <= PROD_W'(row_scale) * PROD_W'(row_sum);
        end
    end

    // Floor shift: drop the fraction bits
    assign shifted = $signed(prod_reg[PROD_W-1:bsmv_pkg::OUT_SHIFT]);

    // Clip to the output range
    generate
        if (SHIFT_W > bsmv_pkg::OUT_W)
        begin : g_clip
            logic [SHIFT_W-bsmv_pkg::OUT_W:0] top_bits;

            assign top_bits = shifted[SHIFT_W-1:bsmv_pkg::OUT_W-1];

            always_comb
            begin
                if (top_bits == '0 || top_bits == '1)
                begin
                    value_next = shifted[bsmv_pkg::OUT_W-1:0];
                    sat_next   = 1'b0;
                end
                else if (shifted[SHIFT_W-1])
                begin
                    value_next = bsmv_pkg::OUT_MIN;
                    sat_next   = 1'b1;
                end
                else
                begin
                    value_next = bsmv_pkg::OUT_MAX;
                    sat_next   = 1'b1;
                end
            end
        end
        else
        begin : g_fit
            assign value_next = bsmv_pkg::OUT_W'(shifted);
            assign sat_next   = 1'b0;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en.out_load)
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign row_value = value_reg;
    assign saturated = sat_reg;

endmodule

// File: test/tb_binary_sign_matrix_vector.sv
`timescale 1ns / 1ps

module tb_binary_sign_matrix_vector;

    localparam int BIG_LEN = 905;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [bsmv_pkg::ADDR_W-1:0] paddr = '0;
    logic [bsmv_pkg::DATA_W-1:0] pwdata = '0;
    logic [bsmv_pkg::DATA_W-1:0] prdata;
    logic pready;

    logic in_valid = 1'b0;
    logic in_stall;
    bsmv_pkg::in_beat_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    bsmv_pkg::out_beat_t out_data;

    binary_sign_matrix_vector dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always #6 clk = ~clk;

    // Mirror of the block state: scaled vector, load and chunk positions, row sum
    int vec_store [bsmv_pkg::MAX_FEATURES_DEF];
    int fill_pos = 0;
    bit vec_ready = 1'b0;
    int chunk_idx = 0;
    longint row_sum = 0;
    logic [bsmv_pkg::CFG_W-1:0] len_reg = bsmv_pkg::LEN_RESET;

    // Row outputs still owed by the block, oldest first
    bsmv_pkg::out_beat_t row_results_due [$];
    int error_count = 0;
    int gapless_left = 0;

    // One row of the directed table: a register write or a beat
    typedef struct {
        bit                  is_cfg;
        int                  cfg_value;
        bsmv_pkg::in_beat_t  beat;
        bit                  typed;
        bit                  has;
        bsmv_pkg::out_beat_t res;
    } stim_row_t;

    stim_row_t stim_table [$];

    task automatic report_mismatch(string what, longint want, longint got);
        error_count++;
        $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    function automatic void set_vector_length(int v);
        len_reg = v[bsmv_pkg::CFG_W-1:0];
        fill_pos = 0;
        vec_ready = 1'b0;
        chunk_idx = 0;
        row_sum = 0;
    endfunction

    // Advance the mirrored state by one beat and work out the row output it causes
    function automatic void compute_row_output(input bsmv_pkg::in_beat_t b, output bit has,
                                               output bsmv_pkg::out_beat_t res);
        int n;
        int pos;
        int base;
        int k;
        longint prod;
        has = 1'b0;
        res = '0;
        if (len_reg == 0)
            n = 1;
        else if (len_reg > bsmv_pkg::MAX_FEATURES_DEF)
            n = bsmv_pkg::MAX_FEATURES_DEF;
        else
            n = int'(len_reg);
        if (b.op == bsmv_pkg::OP_LOAD)
        begin
            // A load always restarts the row and stores the next element
            pos = (fill_pos >= n) ? 0 : fill_pos;
            vec_ready = 1'b0;
            chunk_idx = 0;
            row_sum = 0;
            vec_store[pos] = int'($signed(b.x_value)) * int'($signed(b.column_scale));
            pos++;
            if (pos >= n)
            begin
                fill_pos = 0;
                vec_ready = 1'b1;
            end
            else
                fill_pos = pos;
        end
        else if (vec_ready)
        begin
            // Add or subtract each covered element, MSB first
            base = chunk_idx * bsmv_pkg::SIGN_W;
            for (k = 0; k < bsmv_pkg::SIGN_W; k++)
            begin
                if (base + k < n)
                begin
                    if (b.sign_bits[bsmv_pkg::SIGN_W-1-k])
                        row_sum += longint'(vec_store[base + k]);
                    else
                        row_sum -= longint'(vec_store[base + k]);
                end
            end
            if (base + bsmv_pkg::SIGN_W < n)
                chunk_idx++;
            else
            begin
                // Scale, floor shift, clip to 32 bits
                prod = longint'($signed(b.row_scale)) * row_sum;
                prod = prod >>> bsmv_pkg::OUT_SHIFT;
                res.saturated = 1'b0;
                if (prod > 64'sd2147483647)
                begin
                    prod = 64'sd2147483647;
                    res.saturated = 1'b1;
                end
                if (prod < -64'sd2147483648)
                begin
                    prod = -64'sd2147483648;
                    res.saturated = 1'b1;
                end
                res.row_value = prod[bsmv_pkg::OUT_W-1:0];
                has = 1'b1;
                chunk_idx = 0;
                row_sum = 0;
            end
        end
    endfunction

    function automatic bsmv_pkg::in_beat_t make_beat(logic op, int x, int cs, int sb, int rs);
        bsmv_pkg::in_beat_t b;
        b.op = op;
        b.x_value = x[bsmv_pkg::X_W-1:0];
        b.column_scale = cs[bsmv_pkg::SCALE_W-1:0];
        b.sign_bits = sb[bsmv_pkg::SIGN_W-1:0];
        b.row_scale = rs[bsmv_pkg::SCALE_W-1:0];
        return b;
    endfunction

    function automatic stim_row_t cfg_row(int v);
        stim_row_t r;
        r.is_cfg = 1'b1;
        r.cfg_value = v;
        r.beat = '0;
        r.typed = 1'b0;
        r.has = 1'b0;
        r.res = '0;
        return r;
    endfunction

    // typed rows carry their own expectation; the rest use the predictor
    function automatic stim_row_t beat_row(bsmv_pkg::in_beat_t b, bit typed, bit has, int val);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.cfg_value = 0;
        r.beat = b;
        r.typed = typed;
        r.has = has;
        r.res.row_value = val;
        r.res.saturated = 1'b0;
        return r;
    endfunction

    function automatic int pick16();
        unique case ($urandom_range(0, 19))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return int'($urandom());
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (gapless_left > 0)
        begin
            gapless_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            gapless_left = $urandom_range(50, 150);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Offer one beat, wait for it to be taken, then queue its expected output
    task automatic send_beat(bsmv_pkg::in_beat_t b, bit typed, bit has,
                             bsmv_pkg::out_beat_t res);
        bit model_has;
        bsmv_pkg::out_beat_t model_res;
        int gap;
        in_data <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        compute_row_output(b, model_has, model_res);
        if (typed)
        begin
            if (has)
                row_results_due.push_back(res);
        end
        else if (model_has)
            row_results_due.push_back(model_res);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (row_results_due.size() != 0)
            @(posedge clk);
        // loads still in flight give no output; let the pipeline empty
        repeat (12) @(posedge clk);
    endtask

    // Write vector_length over APB, then read it back
    task automatic write_vector_length(int v);
        hold_until_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {bsmv_pkg::REG_VECTOR_LENGTH, 2'b00};
        pwdata <= bsmv_pkg::DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        set_vector_length(v);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== bsmv_pkg::DATA_W'(v & 32'h1FFF))
            report_mismatch("vector_length readback", v & 32'h1FFF, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Pick the next random beat from where the vector and row stand
    function automatic bsmv_pkg::in_beat_t next_random_beat();
        bsmv_pkg::in_beat_t b;
        b = make_beat(bsmv_pkg::OP_LOAD, pick16(), pick16(), int'($urandom_range(0, 255)),
                      pick16());
        if (vec_ready)
            b.op = ($urandom_range(0, 99) < 4) ? bsmv_pkg::OP_LOAD : bsmv_pkg::OP_CHUNK;
        else
            b.op = ($urandom_range(0, 99) < 5) ? bsmv_pkg::OP_CHUNK : bsmv_pkg::OP_LOAD;
        return b;
    endfunction

    function automatic int pick_length();
        unique case ($urandom_range(0, 4))
            0: return $urandom_range(1, 8);
            1: return 8 * $urandom_range(1, 4);
            2: return $urandom_range(9, 17);
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    // Check each row output against the oldest one due
    always @(posedge clk)
    begin
        bsmv_pkg::out_beat_t due;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (row_results_due.size() == 0)
                report_mismatch("row output with none due", 0, $signed(out_data.row_value));
            else
            begin
                due = row_results_due.pop_front();
                if (out_data.row_value !== due.row_value)
                    report_mismatch("row_value", $signed(due.row_value),
                                    $signed(out_data.row_value));
                if (out_data.saturated !== due.saturated)
                    report_mismatch("saturated", due.saturated, out_data.saturated);
            end
        end
    end

    // Receiver stall: short and long bursts, with free-running stretches
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    out_stall <= 1'b0;
                    stall_left = $urandom_range(200, 400);
                end
                else if (r < 55)
                begin
                    out_stall <= 1'b0;
                    stall_left = $urandom_range(1, 20);
                end
                else if (r < 92)
                begin
                    out_stall <= 1'b1;
                    stall_left = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    stall_left = $urandom_range(8, 40);
                end
            end
            else
                stall_left--;
        end
    end

    initial
    begin
        #15_000_000;
        $display("tb_binary_sign_matrix_vector: errors");
        $finish;
    end

    initial
    begin
        int i;
        int ph;
        int r;
        int rows;
        stim_row_t row;
        bsmv_pkg::in_beat_t b;

        // Directed table. Reset length is 4096, so the first chunk finds no vector.
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'hFF, 16384),
                                      1, 0, 0));
        stim_table.push_back(cfg_row(1));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_LOAD, 256, 16384, 0, 0), 1, 0, 0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'h80, 16384),
                                      1, 1, 256));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'h00, 16384),
                                      1, 1, -256));
        // bits past the length do not count
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'h7F, 16384),
                                      1, 1, -256));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'h80, 0), 1, 1, 0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'h80, -16384),
                                      1, 1, -256));
        // zero length acts as one
        stim_table.push_back(cfg_row(0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_LOAD, -32768, -32768, 0, 0),
                                      1, 0, 0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'hFF, -32768),
                                      1, 1, -131072));
        // reload while ready
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_LOAD, 32767, -32768, 0, 0),
                                      1, 0, 0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'h80, 32767),
                                      0, 0, 0));
        // floor shift: minus one stays minus one
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_LOAD, -1, 1, 0, 0), 1, 0, 0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'h80, 1), 1, 1, -1));
        // two-chunk rows
        stim_table.push_back(cfg_row(9));
        for (i = 0; i < 9; i++)
            stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_LOAD, 256 * (i + 1), 16384,
                                                    0, 0), 1, 0, 0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'hA5, 0), 1, 0, 0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'h80, 16384),
                                      0, 0, 0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'hFF, 0), 1, 0, 0));
        // load mid row drops the partial row, and the vector is no longer ready
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_LOAD, 1, 1, 0, 0), 1, 0, 0));
        stim_table.push_back(beat_row(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'hFF, 16384),
                                      1, 0, 0));

        // Hold reset, then release
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (i = 0; i < stim_table.size(); i++)
        begin
            row = stim_table[i];
            if (row.is_cfg)
                write_vector_length(row.cfg_value);
            else
                send_beat(row.beat, row.typed, row.has, row.res);
        end

        // Random phases at short lengths
        for (ph = 0; ph < 6; ph++)
        begin
            write_vector_length(pick_length());
            for (i = 0; i < 70; i++)
            begin
                // let the block drain completely once mid-phase
                if (ph == 3 && i == 35)
                    hold_until_drained();
                send_beat(next_random_beat(), 1'b0, 1'b0, '0);
            end
        end

        // All ones clamps to the full store; a few loads leave the vector unready
        write_vector_length(8191);
        for (i = 0; i < 6; i++)
            send_beat(make_beat(bsmv_pkg::OP_LOAD, pick16(), pick16(), 0, 0),
                      1'b0, 1'b0, '0);
        send_beat(make_beat(bsmv_pkg::OP_CHUNK, 0, 0, 8'hFF, 16384), 1'b1, 1'b0, '0);

        // Long vector with the largest elements, last chunk partly past the end
        write_vector_length(BIG_LEN);
        for (i = 0; i < BIG_LEN; i++)
            send_beat(make_beat(bsmv_pkg::OP_LOAD, -32768, -32768,
                                int'($urandom_range(0, 255)), pick16()), 1'b0, 1'b0, '0);
        rows = (BIG_LEN + bsmv_pkg::SIGN_W - 1) / bsmv_pkg::SIGN_W;
        for (r = 0; r < 3; r++)
        begin
            for (i = 0; i < rows; i++)
            begin
                b = make_beat(bsmv_pkg::OP_CHUNK, pick16(), pick16(),
                              int'($urandom_range(0, 255)), pick16());
                if (r == 0)
                begin
                    b.sign_bits = 8'hFF;
                    b.row_scale = 16'h8000;
                end
                else if (r == 1)
                begin
                    b.sign_bits = 8'h00;
                    b.row_scale = 16'h7FFF;
                end
                send_beat(b, 1'b0, 1'b0, '0);
            end
        end

        // Drain and finish
        in_valid <= 1'b0;
        while (row_results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_binary_sign_matrix_vector: clean");
        else
            $display("tb_binary_sign_matrix_vector: errors");
        $finish;
    end

endmodule
